// ===== src/irb_pkg.sv =====
// ----------------------------------------------------------------------------
// IR burst recovery package
// Shared widths, register indexes, reset values and controller/datapath links.
// ----------------------------------------------------------------------------
package irb_pkg;

    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CNT_W      = 9;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned DIV_STEP_W = 5;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BURST_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NOISE_FLOOR     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_LIMIT    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_ON      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_OFF     = 3'd4;

    // Register values after reset
    localparam logic [CFG_W-1:0] RST_BURST_THRESHOLD = 16'd700;
    localparam logic [CFG_W-1:0] RST_NOISE_FLOOR     = 16'd100;
    localparam logic [CNT_W-1:0] RST_SAMPLE_LIMIT    = 9'd300;
    localparam logic [CFG_W-1:0] RST_DEFAULT_ON      = 16'd211;
    localparam logic [CFG_W-1:0] RST_DEFAULT_OFF     = 16'd420;

    // Controller to datapath
    typedef struct packed {
        logic take_item;
        logic push_burst;
        logic push_gap;
        logic start_div;
        logic push_final;
    } t_irb_cmd;

    // Datapath to controller
    typedef struct packed {
        logic close_burst;    // beat being taken closes the burst
        logic item_final;     // beat being taken is the last edge
        logic final_pending;  // last edge taken, final beat still owed
        logic out_free;       // output register can load this cycle
        logic div_busy;
    } t_irb_sts;

endpackage

// ===== src/irb_divider.sv =====
// ----------------------------------------------------------------------------
// IR burst recovery divider
// Restoring 32 by 9 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module irb_divider
    import irb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [LEN_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic [LEN_W-1:0]  o_quotient
);

    logic                  r_busy;
    logic [DIV_STEP_W-1:0] r_step;
    logic [CNT_W-1:0]      r_rem;
    logic [LEN_W-1:0]      r_quo;
    logic [CNT_W-1:0]      r_div;

    logic [CNT_W:0]        n_trial;
    logic                  n_fits;
    logic [CNT_W:0]        n_diff;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        n_trial = {r_rem, r_quo[LEN_W-1]};
        n_fits  = (n_trial >= {1'b0, r_div});
        n_diff  = n_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_fits ? n_diff[CNT_W-1:0] : n_trial[CNT_W-1:0];
            r_quo <= {r_quo[LEN_W-2:0], n_fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== src/irb_datapath.sv =====
// ----------------------------------------------------------------------------
// IR burst recovery datapath
// Interval math, burst and average state, config registers, output register.
// ----------------------------------------------------------------------------
module irb_datapath
    import irb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic [STAMP_W-1:0]    i_stamp,
    input  logic                  i_final_edge,
    input  logic                  i_out_ready,
    input  t_irb_cmd              i_cmd,
    output t_irb_sts              o_sts,
    output logic                  o_out_valid,
    output logic [LEN_W-1:0]      o_out_len,
    output logic                  o_out_last,
    output logic [LEN_W-1:0]      o_out_on_avg,
    output logic [LEN_W-1:0]      o_out_off_avg,
    output logic                  o_out_dflt
);

    // Configuration
    logic [CFG_W-1:0] r_burst_threshold;
    logic [CFG_W-1:0] r_noise_floor;
    logic [CNT_W-1:0] r_sample_limit;
    logic [CFG_W-1:0] r_default_on;
    logic [CFG_W-1:0] r_default_off;

    // Capture state
    logic [STAMP_W-1:0] r_prev_stamp;
    logic [1:0]         r_seen;
    logic [LEN_W-1:0]   r_acc;
    logic               r_phase_on;
    logic               r_emitted;
    logic [LEN_W-1:0]   r_on_sum;
    logic [CNT_W-1:0]   r_on_cnt;
    logic [LEN_W-1:0]   r_off_sum;
    logic [CNT_W-1:0]   r_off_cnt;
    logic               r_final_pending;
    logic [LEN_W-1:0]   r_burst_len;
    logic [LEN_W-1:0]   r_gap_len;

    // Output register
    logic               r_out_valid;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_last;
    logic [LEN_W-1:0]   r_out_on_avg;
    logic [LEN_W-1:0]   r_out_off_avg;
    logic               r_out_dflt;

    logic [LEN_W-1:0]   n_interval;
    logic               n_active;
    logic               n_long;
    logic               n_absorb;
    logic               n_close;
    logic [LEN_W-1:0]   n_acc_sum;
    logic               n_sample_ok;
    logic               n_dflt;
    logic               n_out_free;

    logic               w_div_on_busy;
    logic               w_div_off_busy;
    logic [LEN_W-1:0]   w_on_quo;
    logic [LEN_W-1:0]   w_off_quo;

    always_comb begin
        n_interval  = i_stamp - r_prev_stamp;
        n_active    = (r_seen == 2'd3);
        n_long      = (n_interval > {{(LEN_W-CFG_W){1'b0}}, r_burst_threshold});
        n_absorb    = n_long && r_phase_on
                      && (r_acc <= {{(LEN_W-CFG_W){1'b0}}, r_burst_threshold});
        n_close     = n_long && !n_absorb;
        n_acc_sum   = r_acc + n_interval;
        n_sample_ok = r_emitted
                      && (n_interval >= {{(LEN_W-CFG_W){1'b0}}, r_noise_floor});
        n_dflt      = (r_on_cnt == '0) || (r_off_cnt == '0);
        n_out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_threshold <= RST_BURST_THRESHOLD;
            r_noise_floor     <= RST_NOISE_FLOOR;
            r_sample_limit    <= RST_SAMPLE_LIMIT;
            r_default_on      <= RST_DEFAULT_ON;
            r_default_off     <= RST_DEFAULT_OFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BURST_THRESHOLD: r_burst_threshold <= i_cfg_wdata;
                CFG_NOISE_FLOOR:     r_noise_floor     <= i_cfg_wdata;
                CFG_SAMPLE_LIMIT:    r_sample_limit    <= i_cfg_wdata[CNT_W-1:0];
                CFG_DEFAULT_ON:      r_default_on      <= i_cfg_wdata;
                CFG_DEFAULT_OFF:     r_default_off     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.push_final) begin
            r_prev_stamp    <= '0;
            r_seen          <= '0;
            r_acc           <= '0;
            r_phase_on      <= 1'b1;
            r_emitted       <= 1'b0;
            r_on_sum        <= '0;
            r_on_cnt        <= '0;
            r_off_sum       <= '0;
            r_off_cnt       <= '0;
            r_final_pending <= 1'b0;
        end else if (i_cmd.take_item) begin
            r_prev_stamp    <= i_stamp;
            r_final_pending <= i_final_edge;
            if (!n_active) begin
                r_seen <= r_seen + 2'd1;
            end else if (n_close) begin
                r_acc      <= '0;
                r_emitted  <= 1'b1;
                r_phase_on <= 1'b1;
            end else if (n_absorb) begin
                r_acc      <= n_acc_sum;
                r_phase_on <= 1'b0;
            end else begin
                r_acc      <= n_acc_sum;
                r_phase_on <= !r_phase_on;
                if (r_phase_on) begin
                    if (n_sample_ok && (r_on_cnt < r_sample_limit)) begin
                        r_on_sum <= r_on_sum + n_interval;
                        r_on_cnt <= r_on_cnt + 1'b1;
                    end
                end else begin
                    if (n_sample_ok && (r_off_cnt < r_sample_limit)) begin
                        r_off_sum <= r_off_sum + n_interval;
                        r_off_cnt <= r_off_cnt + 1'b1;
                    end
                end
            end
        end
    end

    // Hold the burst and gap of a closing interval until they go out
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item && n_active && n_close) begin
            r_burst_len <= r_acc;
            r_gap_len   <= n_interval;
        end
    end

    irb_divider u_div_on (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (r_on_sum),
        .i_divisor  (r_on_cnt),
        .o_busy     (w_div_on_busy),
        .o_quotient (w_on_quo)
    );

    irb_divider u_div_off (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (r_off_sum),
        .i_divisor  (r_off_cnt),
        .o_busy     (w_div_off_busy),
        .o_quotient (w_off_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_burst || i_cmd.push_gap || i_cmd.push_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_burst || i_cmd.push_gap) begin
            r_out_len     <= i_cmd.push_burst ? r_burst_len : r_gap_len;
            r_out_last    <= 1'b0;
            r_out_on_avg  <= '0;
            r_out_off_avg <= '0;
            r_out_dflt    <= 1'b0;
        end else if (i_cmd.push_final) begin
            r_out_len     <= r_acc;
            r_out_last    <= 1'b1;
            r_out_on_avg  <= n_dflt ? {{(LEN_W-CFG_W){1'b0}}, r_default_on} : w_on_quo;
            r_out_off_avg <= n_dflt ? {{(LEN_W-CFG_W){1'b0}}, r_default_off} : w_off_quo;
            r_out_dflt    <= n_dflt;
        end
    end

    always_comb begin
        o_sts.close_burst   = n_active && n_close;
        o_sts.item_final    = i_final_edge;
        o_sts.final_pending = r_final_pending;
        o_sts.out_free      = n_out_free;
        o_sts.div_busy      = w_div_on_busy || w_div_off_busy;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_len     = r_out_len;
    assign o_out_last    = r_out_last;
    assign o_out_on_avg  = r_out_on_avg;
    assign o_out_off_avg = r_out_off_avg;
    assign o_out_dflt    = r_out_dflt;

endmodule

// ===== src/irb_controller.sv =====
// ----------------------------------------------------------------------------
// IR burst recovery controller
// Sequences beat intake, burst/gap output, the average divide and final beat.
// ----------------------------------------------------------------------------
module irb_controller
    import irb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_irb_sts i_sts,
    output logic     o_in_ready,
    output t_irb_cmd o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_BURST  = 6'b000010,
        ST_GAP    = 6'b000100,
        ST_DSTART = 6'b001000,
        ST_DWAIT  = 6'b010000,
        ST_FINAL  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    if (i_sts.close_burst) begin
                        n_state = ST_BURST;
                    end else if (i_sts.item_final) begin
                        n_state = ST_DSTART;
                    end
                end
            end
            ST_BURST: begin
                if (i_sts.out_free) begin
                    o_cmd.push_burst = 1'b1;
                    n_state          = ST_GAP;
                end
            end
            ST_GAP: begin
                if (i_sts.out_free) begin
                    o_cmd.push_gap = 1'b1;
                    n_state        = i_sts.final_pending ? ST_DSTART : ST_IDLE;
                end
            end
            ST_DSTART: begin
                o_cmd.start_div = 1'b1;
                n_state         = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.push_final = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/ir_carrier_burst_recovery.sv =====
// ----------------------------------------------------------------------------
// IR carrier burst recovery
// Turns raw IR edge timestamps into merged burst and gap lengths plus averages.
// ----------------------------------------------------------------------------
// Each input beat is one 32-bit timer stamp taken at an IR edge; tlast marks
// the last edge of a capture. The block forms intervals between stamps
// (modulo 2^32), drops the first two, merges short carrier intervals into a
// burst and sends out burst/gap pairs when a long interval closes a burst.
// On the last edge it sends the remaining burst with tlast set, together with
// the mean on and off carrier intervals (or the configured defaults, flagged
// in tuser, when either side has no samples). A beat that closes a burst is
// followed by a burst and a gap output beat before the next beat is taken;
// on the last edge two bit-serial 32 by 9 bit dividers produce the two
// averages in parallel. A stalled output delays these beats. The output
// register lets the next beat be taken while the previous result still
// waits downstream. Registers must be written through the plain write port
// only while the block is idle; this binds the user, the block does not check.
// After the final beat all capture state takes its reset value; registers stay.
// ----------------------------------------------------------------------------
module ir_carrier_burst_recovery
    import irb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Register write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // Edge stamps in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // [31:0] timestamp
    input  logic                  s_axis_tlast,  // final_edge
    // Intervals out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [95:0]           m_axis_tdata,  // [31:0] interval_length,
                                                 // [63:32] on_average,
                                                 // [95:64] off_average
    output logic                  m_axis_tlast,  // last_interval
    output logic                  m_axis_tuser   // [0] used_defaults
);

    t_irb_cmd         w_cmd;
    t_irb_sts         w_sts;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_on_avg;
    logic [LEN_W-1:0] w_off_avg;

    // Sequence intake, output beats and the divide
    irb_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // Interval math, state and output register
    irb_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_stamp       (s_axis_tdata),
        .i_final_edge  (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .o_out_len     (w_len),
        .o_out_last    (m_axis_tlast),
        .o_out_on_avg  (w_on_avg),
        .o_out_off_avg (w_off_avg),
        .o_out_dflt    (m_axis_tuser)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {w_off_avg, w_on_avg, w_len};

endmodule

// ===== src/irb_checker.sv =====
// ----------------------------------------------------------------------------
// IR burst recovery checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module irb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // Defaults are only reported on the final beat
    a_dflt_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("used_defaults set on a beat without tlast");

    // Burst and gap beats carry zero averages
    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[95:32] == 64'd0))
        else $error("averages nonzero on a non-final beat");

    // Default averages come from 16-bit registers
    a_dflt_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[63:48] == 16'd0) && (m_axis_tdata[95:80] == 16'd0))
        else $error("default average wider than its register");

    // A stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

endmodule

bind ir_carrier_burst_recovery irb_checker u_irb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/tb_ir_carrier_burst_recovery.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IR carrier burst recovery testbench
// Feeds edge stamp captures into the block, tracks the capture state here to
// predict every burst, gap and final interval beat, and compares each output
// beat field by field. Covers directed frame shapes, register extremes,
// random captures and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_ir_carrier_burst_recovery;
    import irb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 48;   // covers the average divide
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 40;
    localparam int IDLE_PCT        = 12;

    // Index with no register behind it: writes must leave every setting alone
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;

    // Shapes of the interval between two stamps
    typedef enum int {IV_CARRIER, IV_NOISE, IV_GAP, IV_WILD} t_interval_kind;

    typedef struct {
        logic [31:0] length;
        logic        last;
        logic [31:0] on_avg;
        logic [31:0] off_avg;
        logic        dflt;
    } t_interval_beat;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;  // [31:0] timestamp
    logic                  s_axis_tlast  = 1'b0; // final_edge
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [95:0]           m_axis_tdata;        // [31:0] interval_length,
                                                // [63:32] on_average,
                                                // [95:64] off_average
    logic                  m_axis_tlast;        // last_interval
    logic                  m_axis_tuser;        // [0] used_defaults

    // Register copies, tracked on every write
    logic [15:0] burst_thr;
    logic [15:0] noise_floor;
    logic [8:0]  sample_limit;
    logic [15:0] dflt_on;
    logic [15:0] dflt_off;

    // Capture state as the block should hold it
    logic [31:0] prev_stamp;
    int          stamps_seen;
    logic [31:0] burst_len;
    logic        on_phase;
    logic        gap_sent;
    logic [31:0] on_total;
    logic [31:0] off_total;
    logic [8:0]  on_samples;
    logic [8:0]  off_samples;

    t_interval_beat pending_intervals[$];

    int  mismatches  = 0;
    int  stall_count = 0;
    int  hold_cycles = 0;
    bit  steady      = 1'b0;  // set to switch off idling on both sides

    ir_carrier_burst_recovery DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Interval prediction
    // ------------------------------------------------------------------------

    // Return all capture state to its reset value; registers stay as written
    function automatic void clear_capture();
        prev_stamp  = '0;
        stamps_seen = 0;
        burst_len   = '0;
        on_phase    = 1'b1;
        gap_sent    = 1'b0;
        on_total    = '0;
        off_total   = '0;
        on_samples  = '0;
        off_samples = '0;
    endfunction

    function automatic void push_interval(input logic [31:0] length, input logic last,
                                          input logic [31:0] on_avg,
                                          input logic [31:0] off_avg, input logic dflt);
        t_interval_beat beat;
        beat.length  = length;
        beat.last    = last;
        beat.on_avg  = on_avg;
        beat.off_avg = off_avg;
        beat.dflt    = dflt;
        pending_intervals.push_back(beat);
    endfunction

    // Advance the capture by one accepted stamp and queue the beats it owes
    function automatic void recover_intervals(input logic [31:0] stamp, input logic fin);
        logic [31:0] span;
        if (stamps_seen >= 3) begin
            span = stamp - prev_stamp;   // wraps modulo 2^32
            if (span > {16'd0, burst_thr}) begin
                if (on_phase && burst_len <= {16'd0, burst_thr}) begin
                    // Long interval while the burst is still short: absorb it
                    burst_len = burst_len + span;
                    on_phase  = 1'b0;
                end else begin
                    // Close the burst: burst beat, then gap beat
                    push_interval(burst_len, 1'b0, '0, '0, 1'b0);
                    push_interval(span, 1'b0, '0, '0, 1'b0);
                    burst_len = '0;
                    gap_sent  = 1'b1;
                    on_phase  = 1'b1;
                end
            end else begin
                burst_len = burst_len + span;
                if (on_phase) begin
                    if (gap_sent && on_samples < sample_limit &&
                        span >= {16'd0, noise_floor}) begin
                        on_total   = on_total + span;
                        on_samples = on_samples + 9'd1;
                    end
                    on_phase = 1'b0;
                end else begin
                    if (gap_sent && off_samples < sample_limit &&
                        span >= {16'd0, noise_floor}) begin
                        off_total   = off_total + span;
                        off_samples = off_samples + 9'd1;
                    end
                    on_phase = 1'b1;
                end
            end
        end else begin
            stamps_seen++;
        end
        prev_stamp = stamp;

        if (fin) begin
            // Fall back to the defaults when either side has no samples
            if (on_samples == 0 || off_samples == 0)
                push_interval(burst_len, 1'b1, {16'd0, dflt_on}, {16'd0, dflt_off}, 1'b1);
            else
                push_interval(burst_len, 1'b1, on_total / on_samples,
                              off_total / off_samples, 1'b0);
            clear_capture();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    endtask

    // Compare every output beat with the oldest pending interval
    always @(posedge i_clk) begin
        t_interval_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_intervals.size() == 0) begin
                report_mismatch("beat with nothing pending", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_intervals.pop_front();
                if (m_axis_tdata[31:0] !== want.length)
                    report_mismatch("interval_length", m_axis_tdata[31:0], want.length);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_interval", {31'd0, m_axis_tlast}, {31'd0, want.last});
                if (m_axis_tdata[63:32] !== want.on_avg)
                    report_mismatch("on_average", m_axis_tdata[63:32], want.on_avg);
                if (m_axis_tdata[95:64] !== want.off_avg)
                    report_mismatch("off_average", m_axis_tdata[95:64], want.off_avg);
                if (m_axis_tuser !== want.dflt)
                    report_mismatch("used_defaults", {31'd0, m_axis_tuser}, {31'd0, want.dflt});
            end
        end
    end

    // Drop the run when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: hold off for a requested stretch, else idle at random
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_BURST_THRESHOLD: burst_thr    = value;
            CFG_NOISE_FLOOR:     noise_floor  = value;
            CFG_SAMPLE_LIMIT:    sample_limit = value[CNT_W-1:0];
            CFG_DEFAULT_ON:      dflt_on      = value;
            CFG_DEFAULT_OFF:     dflt_off     = value;
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [15:0] thr, input logic [15:0] floor_val,
                                 input logic [15:0] limit, input logic [15:0] on_val,
                                 input logic [15:0] off_val);
        write_reg(CFG_BURST_THRESHOLD, thr);
        write_reg(CFG_NOISE_FLOOR, floor_val);
        write_reg(CFG_SAMPLE_LIMIT, limit);
        write_reg(CFG_DEFAULT_ON, on_val);
        write_reg(CFG_DEFAULT_OFF, off_val);
    endtask

    // Offer one stamp beat and return once it is taken
    task automatic send_stamp(input logic [31:0] stamp, input logic fin);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        recover_intervals(stamp, fin);
    endtask

    // Lower valid, let every pending beat arrive, then let the divider settle
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_intervals.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_interval(input t_interval_kind kind);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = '0;
        hi = {16'd0, burst_thr};
        case (kind)
            IV_CARRIER: begin
                if (noise_floor <= burst_thr)
                    lo = {16'd0, noise_floor};
                return $urandom_range(hi, lo);
            end
            IV_NOISE: begin
                if (noise_floor == 0)
                    return '0;
                if ({16'd0, noise_floor} - 1 < hi)
                    hi = {16'd0, noise_floor} - 1;
                return $urandom_range(hi, 0);
            end
            IV_GAP:  return $urandom_range(hi + 40000, hi + 1);
            default: return $urandom();
        endcase
    endfunction

    // One capture: random start stamp, then intervals of mixed shape. A broken
    // capture is half wild intervals and may end without its last edge.
    task automatic send_capture(input int edges, input int gap_pct, input bit broken);
        logic [31:0]    stamp;
        logic           closes;
        int             roll;
        t_interval_kind kind;
        stamp  = $urandom();
        closes = !broken || ($urandom_range(1) == 1);
        for (int i = 0; i < edges; i++) begin
            send_stamp(stamp, closes && (i == edges - 1));
            roll = $urandom_range(99);
            if (broken)
                kind = (roll < 50) ? IV_WILD : IV_CARRIER;
            else if (roll < gap_pct)
                kind = IV_GAP;
            else if (roll < gap_pct + 10)
                kind = IV_NOISE;
            else if (roll < gap_pct + 13)
                kind = IV_WILD;
            else
                kind = IV_CARRIER;
            stamp = stamp + pick_interval(kind);
        end
    endtask

    task automatic run_random_items(input int items);
        int edges;
        while (items > 0) begin
            edges = $urandom_range(20, 3);
            if (edges > items)
                edges = items;
            send_capture(edges, $urandom_range(35, 10), $urandom_range(99) < 10);
            items -= edges;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Last edge before any interval was processed: zero burst, default averages
    task automatic test_short_captures();
        send_stamp(32'hFFFF_FFFF, 1'b1);
        send_stamp(32'h0000_0000, 1'b0);
        send_stamp(32'h0000_0005, 1'b0);
        send_stamp(32'h8000_0000, 1'b1);
        wait_idle();
    endtask

    // Hand-built frame: absorbed long interval, closing gaps, the threshold on
    // both sides, noise samples, a stamp wrap and an accumulator wrap, and a
    // last edge with real averages
    task automatic test_frame_shapes();
        logic [31:0] steps [15] = '{32'd123, 32'd456, 32'd9000, 32'd560, 32'd4500,
                                    32'd560, 32'd600, 32'd50, 32'd700, 32'd701,
                                    32'd0, 32'd0, 32'hFFFF_FF00, 32'd300, 32'd400};
        logic [31:0] stamp;
        stamp = 32'hFFFF_FE00;
        send_stamp(stamp, 1'b0);
        for (int i = 0; i < 15; i++) begin
            stamp = stamp + steps[i];
            send_stamp(stamp, i == 14);
        end
        wait_idle();
    endtask

    // Extremes of every register; upper wdata bits above the sample limit are
    // set to show they are dropped. The zero limit stops all sample counting.
    task automatic test_register_extremes();
        set_registers(16'h0000, 16'h0000, 16'hFE01, 16'h0000, 16'h0000);
        run_random_items(40);
        wait_idle();
        set_registers(16'hFFFF, 16'hFFFF, 16'h01FF, 16'hFFFF, 16'hFFFF);
        run_random_items(40);
        wait_idle();
        set_registers(16'd700, 16'd100, 16'h0200, 16'h1234, 16'hEDCB);
        write_reg(CFG_SPARE, 16'($urandom()));
        run_random_items(30);
        wait_idle();
    endtask

    // Random mid-range registers with small sample limits so they saturate
    task automatic test_random_captures();
        logic [15:0] thr;
        for (int phase = 0; phase < 3; phase++) begin
            thr = 16'($urandom_range(3000, 50));
            set_registers(thr, 16'($urandom_range(thr, 0)),
                          {7'($urandom()), 9'($urandom_range(12, 1))},
                          16'($urandom()), 16'($urandom()));
            steady = (phase == 1);   // one stretch with no idling at all
            run_random_items(30);
            wait_idle();
            steady = 1'b0;
        end
    endtask

    // Hold the output off long enough that the block fills and stalls input
    task automatic test_output_backpressure();
        set_registers(16'd700, 16'd100, 16'd300, 16'd211, 16'd420);
        hold_cycles = HOLD_OFF_CYCLES;
        send_capture(40, 50, 1'b0);
        wait_idle();
    endtask

    initial begin
        burst_thr    = RST_BURST_THRESHOLD;
        noise_floor  = RST_NOISE_FLOOR;
        sample_limit = RST_SAMPLE_LIMIT;
        dflt_on      = RST_DEFAULT_ON;
        dflt_off     = RST_DEFAULT_OFF;
        clear_capture();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_captures();
        test_frame_shapes();
        test_register_extremes();
        test_random_captures();
        test_output_backpressure();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
